/* rtl/u16d_pkg.sv */
// Shared types, codes and helpers for the UTF-16 byte stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package u16d_pkg;

  // Decoupling queue between the front and back parts
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int VALUE_W = 21;
  localparam int NB_W    = 3;

  localparam logic [NB_W-1:0] NB_ONE  = 3'd1;
  localparam logic [NB_W-1:0] NB_TWO  = 3'd2;
  localparam logic [NB_W-1:0] NB_FOUR = 3'd4;

  localparam logic [VALUE_W-1:0] SUPP_BASE = 21'h10000;

  // Top six bits of a surrogate unit, and of its first byte in big-endian order
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_EOS  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_CODE   = 2'd0,
    KIND_LONE_H = 2'd1,
    KIND_LONE_L = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_t;

  // Pending-byte state: equals the number of bytes held
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_ONE      = 2'd1,
    MODE_HELD     = 2'd2,
    MODE_HELD_ONE = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [NB_W-1:0]     nbytes;
  } res_t;

  // One queue entry: all reports caused by one input beat
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  function automatic logic [15:0] pair_unit(input logic [7:0] first,
                                            input logic [7:0] second,
                                            input logic       be);
    pair_unit = be ? {first, second} : {second, first};
  endfunction

  function automatic logic is_high_surr(input logic [15:0] u);
    is_high_surr = (u[15:10] == SURR_HIGH_TAG);
  endfunction

  function automatic logic is_low_surr(input logic [15:0] u);
    is_low_surr = (u[15:10] == SURR_LOW_TAG);
  endfunction

endpackage

`default_nettype wire

/* rtl/utf16_byte_stream_decoder_top.sv */
// Top level of the UTF-16 byte stream decoder.
//
// Input stream (s_*): one beat per stream byte. s_tuser is the command:
// 0 feeds s_tdata as a data byte, 1 marks end of stream (s_tdata ignored).
// Output stream (m_*): one beat per report. m_tuser is the kind (code point,
// lone high surrogate, lone low surrogate, truncated byte), m_tdata carries
// the value and the number of stream bytes it covers, m_tlast marks the
// final report caused by one input beat.
// Byte order comes from cfg_wdata written with cfg_we (1 = big-endian);
// write it only while the decoder is idle.
//
// Throughput: one input byte per cycle while the queue is not full. A byte
// that produces two reports (high surrogate then ordinary unit, or end of
// stream with three pending bytes) holds the output for two beats; the
// two-entry queue between the front and back parts absorbs that extra cycle.
// Each report group is registered into the queue when its byte is accepted.
// When the receiver stalls, reports wait in the queue; s_tready drops once
// the queue is full and rises as soon as a group leaves it.
// Reset (synchronous rst) selects little-endian, drops pending bytes and
// empties the queue; s_tready is high as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module utf16_byte_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  input  wire logic        s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // value[20:0], unit_bytes[23:21]
  output logic [1:0]       m_tuser,   // kind[1:0]
  output logic             m_tlast
);

  logic              push, pop, q_full, q_not_empty;
  u16d_pkg::entry_t  push_entry, head;

  // Front: assemble units and classify them into report groups
  u16d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (s_tuser),
    .in_byte    (s_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple front acceptance from output stalls
  u16d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty)
  );

  // Back: emit each group as one or two beats
  u16d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .not_empty  (q_not_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // The only two-report groups open with a lone high surrogate
  a_pair_opens_lone_high: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == u16d_pkg::KIND_LONE_H))
    else $error("non-final report is not a lone high surrogate");

  // The second report of a pair follows right after the first
  a_pair_second_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("second report of a pair missing");

  // Code points cover two or four bytes
  a_code_width: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == u16d_pkg::KIND_CODE)) |->
      ((m_tdata[23:21] == u16d_pkg::NB_TWO) || (m_tdata[23:21] == u16d_pkg::NB_FOUR)))
    else $error("code point with wrong byte count");

  // A truncated byte is one byte and always the final report
  a_trunc_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == u16d_pkg::KIND_TRUNC)) |->
      (m_tlast && (m_tdata[23:21] == u16d_pkg::NB_ONE) && (m_tdata[20:8] == '0)))
    else $error("malformed truncated byte report");

endmodule

`default_nettype wire

/* rtl/u16d_front.sv */
// Front part: byte acceptance, unit assembly and surrogate classification.
`timescale 1ns / 1ps
`default_nettype none

module u16d_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_cmd,
  input  wire logic [7:0]      in_byte,
  input  wire logic            q_full,
  output logic                 push,
  output u16d_pkg::entry_t     push_entry
);

  u16d_pkg::mode_t mode, mode_next;
  logic            big_endian;
  logic [7:0]      store0, store1, store2;
  logic [7:0]      store0_next, store1_next, store2_next;
  logic            accept;
  logic            has_res;
  logic [15:0]     held, u_one, u_two;
  logic [20:0]     supp;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && has_res;

  assign held  = {store0, store1};
  assign u_one = u16d_pkg::pair_unit(store0, in_byte, big_endian);
  assign u_two = u16d_pkg::pair_unit(store2, in_byte, big_endian);
  assign supp  = {1'b0, held[9:0], u_two[9:0]} + u16d_pkg::SUPP_BASE;

  always_comb begin
    mode_next   = mode;
    store0_next = store0;
    store1_next = store1;
    store2_next = store2;
    has_res     = 1'b0;
    push_entry  = '0;
    if (in_cmd == u16d_pkg::CMD_EOS) begin
      // Flush whatever is pending as errors
      mode_next = u16d_pkg::MODE_IDLE;
      case (mode)
        u16d_pkg::MODE_ONE: begin
          has_res              = 1'b1;
          push_entry.r0.kind   = u16d_pkg::KIND_TRUNC;
          push_entry.r0.value  = {13'd0, store0};
          push_entry.r0.nbytes = u16d_pkg::NB_ONE;
        end
        u16d_pkg::MODE_HELD: begin
          has_res              = 1'b1;
          push_entry.r0.kind   = u16d_pkg::KIND_LONE_H;
          push_entry.r0.value  = {5'd0, held};
          push_entry.r0.nbytes = u16d_pkg::NB_TWO;
        end
        u16d_pkg::MODE_HELD_ONE: begin
          has_res              = 1'b1;
          push_entry.two       = 1'b1;
          push_entry.r0.kind   = u16d_pkg::KIND_LONE_H;
          push_entry.r0.value  = {5'd0, held};
          push_entry.r0.nbytes = u16d_pkg::NB_TWO;
          push_entry.r1.kind   = u16d_pkg::KIND_TRUNC;
          push_entry.r1.value  = {13'd0, store2};
          push_entry.r1.nbytes = u16d_pkg::NB_ONE;
        end
        default: begin
        end
      endcase
    end else begin
      case (mode)
        u16d_pkg::MODE_IDLE: begin
          store0_next = in_byte;
          mode_next   = u16d_pkg::MODE_ONE;
        end
        u16d_pkg::MODE_ONE: begin
          if (u16d_pkg::is_high_surr(u_one)) begin
            // Hold the high surrogate as high byte, low byte
            store0_next = u_one[15:8];
            store1_next = u_one[7:0];
            mode_next   = u16d_pkg::MODE_HELD;
          end else begin
            has_res              = 1'b1;
            push_entry.r0.kind   = u16d_pkg::is_low_surr(u_one) ?
                                   u16d_pkg::KIND_LONE_L : u16d_pkg::KIND_CODE;
            push_entry.r0.value  = {5'd0, u_one};
            push_entry.r0.nbytes = u16d_pkg::NB_TWO;
            mode_next            = u16d_pkg::MODE_IDLE;
          end
        end
        u16d_pkg::MODE_HELD: begin
          if (big_endian && (in_byte[7:2] != u16d_pkg::SURR_LOW_TAG)) begin
            // Big-endian lead byte cannot start a low surrogate: report early
            has_res              = 1'b1;
            push_entry.r0.kind   = u16d_pkg::KIND_LONE_H;
            push_entry.r0.value  = {5'd0, held};
            push_entry.r0.nbytes = u16d_pkg::NB_TWO;
            store0_next          = in_byte;
            mode_next            = u16d_pkg::MODE_ONE;
          end else begin
            store2_next = in_byte;
            mode_next   = u16d_pkg::MODE_HELD_ONE;
          end
        end
        default: begin
          has_res = 1'b1;
          if (u16d_pkg::is_low_surr(u_two)) begin
            push_entry.r0.kind   = u16d_pkg::KIND_CODE;
            push_entry.r0.value  = supp;
            push_entry.r0.nbytes = u16d_pkg::NB_FOUR;
            mode_next            = u16d_pkg::MODE_IDLE;
          end else if (u16d_pkg::is_high_surr(u_two)) begin
            push_entry.r0.kind   = u16d_pkg::KIND_LONE_H;
            push_entry.r0.value  = {5'd0, held};
            push_entry.r0.nbytes = u16d_pkg::NB_TWO;
            store0_next          = u_two[15:8];
            store1_next          = u_two[7:0];
            mode_next            = u16d_pkg::MODE_HELD;
          end else begin
            push_entry.two       = 1'b1;
            push_entry.r0.kind   = u16d_pkg::KIND_LONE_H;
            push_entry.r0.value  = {5'd0, held};
            push_entry.r0.nbytes = u16d_pkg::NB_TWO;
            push_entry.r1.kind   = u16d_pkg::KIND_CODE;
            push_entry.r1.value  = {5'd0, u_two};
            push_entry.r1.nbytes = u16d_pkg::NB_TWO;
            mode_next            = u16d_pkg::MODE_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= u16d_pkg::MODE_IDLE;
      big_endian <= 1'b0;
    end else begin
      if (accept) begin
        mode <= mode_next;
      end
      if (cfg_we) begin
        big_endian <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store0 <= store0_next;
      store1 <= store1_next;
      store2 <= store2_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/u16d_queue.sv */
// Short queue of decoded report groups between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module u16d_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire u16d_pkg::entry_t    push_entry,
  output logic                     full,
  input  wire logic                pop,
  output u16d_pkg::entry_t         head,
  output logic                     not_empty
);

  u16d_pkg::entry_t                 mem [u16d_pkg::Q_DEPTH];
  logic [u16d_pkg::Q_PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [u16d_pkg::Q_CNT_W-1:0]     count;

  assign full      = (count == u16d_pkg::Q_CNT_W'(u16d_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Pointers wrap naturally: depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/u16d_back.sv */
// Back part: serializes each queued group into one or two output beats.
`timescale 1ns / 1ps
`default_nettype none

module u16d_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire u16d_pkg::entry_t    head,
  input  wire logic                not_empty,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,
  output logic [1:0]               m_tuser,
  output logic                     m_tlast
);

  logic             phase;
  logic             beat;
  u16d_pkg::res_t   cur;

  assign cur      = phase ? head.r1 : head.r0;
  assign m_tvalid = not_empty;
  assign m_tlast  = !head.two || phase;
  assign m_tdata  = {cur.nbytes, cur.value};
  assign m_tuser  = cur.kind;
  assign beat     = not_empty && m_tready;
  assign pop      = beat && m_tlast;

  // Advance to the second report of a pair, drop back after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (beat) begin
      phase <= !m_tlast;
    end
  end

endmodule

`default_nettype wire
